### src/sw_pkg.sv
// ----------------------------------------------------------------------------
// sw_pkg
// Shared widths, constants and types of the sliding window mean/stddev block.
// ----------------------------------------------------------------------------
package sw_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int STD_W     = 23;
	localparam int LEN_W     = 9;
	localparam int SQ_PROD_W = 48;

	localparam logic [LEN_W-1:0] LEN_RESET = 9'd100;
	localparam logic [STD_W-1:0] STD_MAX   = 23'h7FFFFF;

	typedef struct packed {
		logic done;
		logic full;
	} win_stat_t;

endpackage

### src/sliding_window_mean_stddev.sv
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev
// Moving-window mean and standard deviation of Q12.12 samples.
//
//   channel  signals                                   handshake
//   -------  ----------------------------------------  ---------------
//   in       sample                                    sample_valid/ready
//   out      mean_value, std_dev, window_full          result_valid/ready
//   cfg      cfg_wr_data (window_len)                  cfg_wr_en
//
// One item at a time; a new sample is taken only in the idle state.
// Once the window is full, each item also runs the bit-serial divider over
// the sum of squares and the square root.
// Reset or a window_len write empties the window; no clearing pass is needed.
// A result waiting on result_ready holds only the final hand-over; the next
// item is taken once the current one is in the output register.
// ----------------------------------------------------------------------------
module sliding_window_mean_stddev #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [sw_pkg::LEN_W-1:0]             cfg_wr_data,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic signed [sw_pkg::SAMPLE_W-1:0]   sample,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [sw_pkg::SAMPLE_W-1:0]   mean_value,
	output logic [sw_pkg::STD_W-1:0]             std_dev,
	output logic                                 window_full
);

	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int N_W   = $clog2(WINDOW_MAX+1);
	localparam int SUM_W = sw_pkg::SAMPLE_W + PTR_W;
	localparam int SQ_W  = 47 + PTR_W;
	localparam int RW    = (SQ_W + 1) / 2;
	localparam int PW    = sw_pkg::SQ_PROD_W;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_WIN  = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_VAR  = 7'b0010000,
		S_SQRT = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t                             state_q;
	logic [sw_pkg::LEN_W-1:0]           len_q;
	logic [N_W-1:0]                     n_eff;

	logic                               accept;
	logic signed [SUM_W-1:0]            win_sum;
	logic [SQ_W-1:0]                    win_sumsq;
	sw_pkg::win_stat_t                  win_stat;

	logic                               div_start;
	logic [SUM_W-1:0]                   sum_abs;
	logic [SUM_W-1:0]                   mean_quo;
	logic                               mean_done;
	logic [SQ_W-1:0]                    sq_quo;
	logic                               sq_done;

	logic                               sqrt_start;
	logic [SQ_W-1:0]                    var_val;
	logic [RW-1:0]                      root;
	logic                               sqrt_done;

	logic                               neg_q;
	logic [PW-1:0]                      msq_q;
	logic signed [sw_pkg::SAMPLE_W-1:0] mean_r_q;
	logic [sw_pkg::STD_W-1:0]           std_r_q;
	logic                               full_r_q;
	logic                               valid_q;
	logic                               out_free;
	logic [sw_pkg::SAMPLE_W-1:0]        mean_mag;

	always_comb begin
		if (len_q == '0) begin
			n_eff = N_W'(1);
		end else if (32'(len_q) > WINDOW_MAX) begin
			n_eff = N_W'(WINDOW_MAX);
		end else begin
			n_eff = N_W'(len_q);
		end
	end

	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign div_start    = (state_q == S_WIN) && win_stat.done && win_stat.full;
	assign sum_abs      = win_sum[SUM_W-1] ? $unsigned(-win_sum) : $unsigned(win_sum);
	assign sqrt_start   = (state_q == S_VAR);
	assign var_val      = (sq_quo > SQ_W'(msq_q)) ? (sq_quo - SQ_W'(msq_q)) : '0;
	assign mean_mag     = mean_quo[sw_pkg::SAMPLE_W-1:0];
	assign out_free     = !valid_q || result_ready;

	sw_win #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_wr_en),
		.n      (n_eff),
		.start  (accept),
		.sample (sample),
		.sum    (win_sum),
		.sumsq  (win_sumsq),
		.stat   (win_stat)
	);

	sw_div #(
		.DW (SUM_W),
		.VW (N_W)
	) u_div_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_abs),
		.divisor  (n_eff),
		.quotient (mean_quo),
		.done     (mean_done)
	);

	sw_div #(
		.DW (SQ_W),
		.VW (N_W)
	) u_div_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (win_sumsq),
		.divisor  (n_eff),
		.quotient (sq_quo),
		.done     (sq_done)
	);

	sw_sqrt #(
		.VW (SQ_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (var_val),
		.root     (root),
		.done     (sqrt_done)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_WIN: begin
				neg_q    <= win_sum[SUM_W-1];
				mean_r_q <= '0;
				std_r_q  <= '0;
				full_r_q <= 1'b0;
			end
			S_DIV: begin
				if (mean_done) begin
					mean_r_q <= neg_q ? -mean_mag : mean_mag;
				end
			end
			S_MUL: begin
				msq_q    <= PW'(mean_mag) * PW'(mean_mag);
			end
			S_SQRT: begin
				if (sqrt_done) begin
					std_r_q  <= (root > RW'(sw_pkg::STD_MAX)) ? sw_pkg::STD_MAX
					            : root[sw_pkg::STD_W-1:0];
					full_r_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if ((state_q == S_OUT) && out_free) begin
			mean_value  <= mean_r_q;
			std_dev     <= std_r_q;
			window_full <= full_r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= sw_pkg::LEN_RESET;
			valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
			if ((state_q == S_OUT) && out_free) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					if (win_stat.done) begin
						state_q <= win_stat.full ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (sq_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_VAR;
				S_VAR:  state_q <= S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = valid_q;

endmodule

### src/sw_win.sv
// ----------------------------------------------------------------------------
// sw_win
// Sample ring memory with running sum and sum of squares. Reads the oldest
// entry, removes it from the sums once the window is full, adds the new item
// and writes it back in its slot.
// ----------------------------------------------------------------------------
module sw_win #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clear,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]        n,
	input  logic                                   start,
	input  logic signed [sw_pkg::SAMPLE_W-1:0]     sample,
	output logic signed [sw_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0] sum,
	output logic [47+$clog2(WINDOW_MAX)-1:0]       sumsq,
	output sw_pkg::win_stat_t                      stat
);

	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int N_W   = $clog2(WINDOW_MAX+1);
	localparam int SUM_W = sw_pkg::SAMPLE_W + PTR_W;
	localparam int SQ_W  = 47 + PTR_W;
	localparam int PW    = sw_pkg::SQ_PROD_W;

	logic signed [sw_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
	logic signed [sw_pkg::SAMPLE_W-1:0] rdata_q;

	logic [PTR_W-1:0]                   ptr_q;
	logic [N_W-1:0]                     fill_q;
	logic signed [SUM_W-1:0]            sum_q;
	logic [SQ_W-1:0]                    sumsq_q;
	logic                               rd_s1;
	logic                               upd_s2;
	logic                               done_q;
	logic                               full_q;

	logic signed [sw_pkg::SAMPLE_W-1:0] smp_s1;
	logic signed [sw_pkg::SAMPLE_W-1:0] smp_s2;
	logic signed [sw_pkg::SAMPLE_W-1:0] old_s2;
	logic [PW-1:0]                      nsq_s2;
	logic [PW-1:0]                      osq_s2;

	logic                               was_full;
	logic signed [sw_pkg::SAMPLE_W-1:0] old_val;
	logic [N_W:0]                       ptr_inc;
	logic [N_W:0]                       fill_inc;

	assign was_full = (fill_q >= n);
	assign old_val  = was_full ? rdata_q : '0;
	assign ptr_inc  = (N_W+1)'(ptr_q) + 1'b1;
	assign fill_inc = (N_W+1)'(fill_q) + 1'b1;

	always_ff @(posedge clk) begin
		if (start) begin
			rdata_q <= ring_mem[ptr_q];
		end
		if (upd_s2) begin
			ring_mem[ptr_q] <= smp_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			smp_s1 <= sample;
		end
		if (rd_s1) begin
			smp_s2 <= smp_s1;
			old_s2 <= old_val;
			nsq_s2 <= $unsigned(PW'(smp_s1) * PW'(smp_s1));
			osq_s2 <= $unsigned(PW'(old_val) * PW'(old_val));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			rd_s1   <= 1'b0;
			upd_s2  <= 1'b0;
			done_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			rd_s1  <= start;
			upd_s2 <= rd_s1;
			done_q <= upd_s2;
			if (clear) begin
				ptr_q   <= '0;
				fill_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end else if (upd_s2) begin
				sum_q   <= sum_q - SUM_W'(old_s2) + SUM_W'(smp_s2);
				sumsq_q <= sumsq_q - SQ_W'(osq_s2) + SQ_W'(nsq_s2);
				if (!was_full) begin
					fill_q <= fill_inc[N_W-1:0];
				end
				if (ptr_inc >= (N_W+1)'(n)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_inc[PTR_W-1:0];
				end
				full_q <= was_full || (fill_inc >= (N_W+1)'(n));
			end
		end
	end

	assign sum       = sum_q;
	assign sumsq     = sumsq_q;
	assign stat.done = done_q;
	assign stat.full = full_q;

endmodule

### src/sw_div.sv
// ----------------------------------------------------------------------------
// sw_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sw_div #(
	parameter int DW = 55,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CW = $clog2(DW+1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### src/sw_sqrt.sv
// ----------------------------------------------------------------------------
// sw_sqrt
// Floor square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module sw_sqrt #(
	parameter int VW = 55
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VW-1:0]         radicand,
	output logic [(VW+1)/2-1:0]   root,
	output logic                  done
);

	localparam int RW = (VW + 1) / 2;
	localparam int PW = 2 * RW;
	localparam int CW = $clog2(RW+1);

	logic [PW-1:0] v_q;
	logic [RW:0]   rem_q;
	logic [RW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [RW+2:0] cur;
	logic [RW+2:0] trial;
	logic [RW+2:0] diff;
	logic          ge;

	assign cur   = {rem_q, v_q[PW-1:PW-2]};
	assign trial = (RW+3)'({root_q, 2'b01});
	assign ge    = (cur >= trial);
	assign diff  = cur - trial;

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= PW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[PW-3:0], 2'b00};
			rem_q  <= ge ? diff[RW:0] : cur[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(RW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule
